[hdl/qrs_pkg.sv]
// Shared types, widths and step functions for the quadratic root solver.
// No dependencies; used by every module of the block.
package qrs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COEF_W    = 32;
    localparam int TOL_W     = 31;
    localparam int THR_W     = TOL_W + FRAC_BITS;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int DISC_W    = PROD_W + 2;
    localparam int RAD_W     = 68;
    localparam int SQ_N      = RAD_W / 2;
    localparam int ROOT_W    = 34;
    localparam int SREM_W    = 36;
    localparam int NUM_W     = ROOT_W + 1;
    localparam int MD_W      = COEF_W + 1;
    localparam int MN_W      = ROOT_W + FRAC_BITS + 1;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [1:0] KIND_NOT_QUAD = 2'd0;
    localparam logic [1:0] KIND_NO_REAL  = 2'd1;
    localparam logic [1:0] KIND_DOUBLE   = 2'd2;
    localparam logic [1:0] KIND_TWO      = 2'd3;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W:0]   nb;
        logic [DISC_W-1:0]        dmag;
    } t_job;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic [SREM_W-1:0] rem;
        logic [RAD_W-1:0]  rad;
    } t_sq;

    typedef struct packed {
        logic [MD_W-1:0] rem;
        logic [MN_W-1:0] dvd;
        logic [MN_W-1:0] quo;
    } t_div;

    // one restoring square-root step, two radicand bits
    function automatic t_sq sq_step(input t_sq s);
        t_sq               r;
        logic [SREM_W-1:0] t;
        logic [SREM_W-1:0] trial;
        t     = {s.rem[SREM_W-3:0], s.rad[RAD_W-1:RAD_W-2]};
        trial = {s.root, 2'b01};
        r.rad = {s.rad[RAD_W-3:0], 2'b00};
        if (t >= trial) begin
            r.rem  = t - trial;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = t;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // one restoring division step, one quotient bit
    function automatic t_div div_step(input t_div s, input logic [MD_W-1:0] md);
        t_div          r;
        logic [MD_W:0] t;
        t     = {s.rem, s.dvd[MN_W-1]};
        r.dvd = {s.dvd[MN_W-2:0], 1'b0};
        if (t >= {1'b0, md}) begin
            r.rem = MD_W'(t - {1'b0, md});
            r.quo = {s.quo[MN_W-2:0], 1'b1};
        end else begin
            r.rem = t[MD_W-1:0];
            r.quo = {s.quo[MN_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

[hdl/qrs_front.sv]
// Front end: takes coefficients, forms the exact discriminant and classifies.
// Depends on qrs_pkg.
module qrs_front import qrs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [COEF_W-1:0] i_a,
    input  logic signed [COEF_W-1:0] i_b,
    input  logic signed [COEF_W-1:0] i_c,
    input  logic [TOL_W-1:0]         i_tol,
    output logic                     o_push,
    input  logic                     i_full,
    output t_job                     o_job
);

    logic                     r_s1_v, r_s2_v;
    logic signed [COEF_W-1:0] r_s1_a;
    logic signed [COEF_W:0]   r_s1_nb;
    logic                     r_s1_nq, r_s1_sx;
    logic [PROD_W-1:0]        r_s1_b2, r_s1_p;
    t_job                     r_s2, n_s2;
    logic [COEF_W-1:0]        n_am, n_bm, n_cm;
    logic [DISC_W-1:0]        n_b2, n_p4;
    logic                     n_dneg;
    logic                     en;

    assign en      = !r_s2_v || !i_full;
    assign o_ready = en;
    assign o_push  = r_s2_v && !i_full;
    assign o_job   = r_s2;

    always_comb begin
        n_am = i_a[COEF_W-1] ? COEF_W'(-i_a) : COEF_W'(i_a);
        n_bm = i_b[COEF_W-1] ? COEF_W'(-i_b) : COEF_W'(i_b);
        n_cm = i_c[COEF_W-1] ? COEF_W'(-i_c) : COEF_W'(i_c);
    end

    always_comb begin
        n_b2   = DISC_W'(r_s1_b2);
        n_p4   = {r_s1_p, 2'b00};
        n_dneg = 1'b0;
        n_s2.a  = r_s1_a;
        n_s2.nb = r_s1_nb;
        if (r_s1_p != '0 && r_s1_sx) begin
            n_s2.dmag = n_b2 + n_p4;
        end else if (n_p4 > n_b2) begin
            n_s2.dmag = n_p4 - n_b2;
            n_dneg    = 1'b1;
        end else begin
            n_s2.dmag = n_b2 - n_p4;
        end
        if (r_s1_nq) begin
            n_s2.kind = KIND_NOT_QUAD;
        end else if (n_s2.dmag < DISC_W'({i_tol, {FRAC_BITS{1'b0}}}) || n_s2.dmag == '0) begin
            n_s2.kind = KIND_DOUBLE;
        end else if (!n_dneg) begin
            n_s2.kind = KIND_TWO;
        end else begin
            n_s2.kind = KIND_NO_REAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
        end
        if (en) begin
            r_s1_a  <= i_a;
            r_s1_nb <= -(COEF_W+1)'(i_b);
            r_s1_nq <= (i_a == '0) || (n_am < COEF_W'(i_tol));
            r_s1_sx <= i_a[COEF_W-1] != i_c[COEF_W-1];
            r_s1_b2 <= n_bm * n_bm;
            r_s1_p  <= n_am * n_cm;
            r_s2    <= n_s2;
        end
    end

endmodule

[hdl/qrs_queue.sv]
// Small first-word-fall-through queue between the front and back ends.
// Depends on qrs_pkg.
module qrs_queue import qrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = r_cnt == (QPTR_W+1)'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
        if (i_push) r_mem[r_wr] <= i_job;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop) else $error("queue underflow");

endmodule

[hdl/qrs_back.sv]
// Back end: pipelined square root, two pipelined dividers, saturation.
// Depends on qrs_pkg.
module qrs_back import qrs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  t_job                     i_job,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0]               o_kind,
    output logic signed [COEF_W-1:0] o_plus,
    output logic signed [COEF_W-1:0] o_minus,
    output logic                     o_clip
);

    logic                     en;
    logic                     sq_v   [SQ_N+1];
    t_job                     sq_job [SQ_N+1];
    t_sq                      sq_st  [SQ_N+1];
    logic                     dv_v   [MN_W+1];
    logic [1:0]               dv_kind[MN_W+1];
    logic                     dv_np  [MN_W+1];
    logic                     dv_nm  [MN_W+1];
    logic [MD_W-1:0]          dv_md  [MN_W+1];
    t_div                     dv_p   [MN_W+1];
    t_div                     dv_m   [MN_W+1];
    logic                     r_out_v;
    logic [1:0]               r_kind;
    logic [COEF_W-1:0]        r_plus, r_minus;
    logic                     r_clip;
    logic [ROOT_W-1:0]        n_s;
    logic signed [NUM_W-1:0]  n_nump, n_numm;
    logic [ROOT_W-1:0]        n_magp, n_magm;
    logic [COEF_W-1:0]        n_am;
    logic [COEF_W-1:0]        n_rp, n_rm;
    logic                     n_cp, n_cm;

    assign en      = !r_out_v || i_ready;
    assign o_pop   = en && i_valid;
    assign o_valid = r_out_v;
    assign o_kind  = r_kind;
    assign o_plus  = r_plus;
    assign o_minus = r_minus;
    assign o_clip  = r_clip;

    assign sq_v[0]        = i_valid;
    assign sq_job[0]      = i_job;
    assign sq_st[0].root  = '0;
    assign sq_st[0].rem   = '0;
    assign sq_st[0].rad   = RAD_W'(i_job.dmag);

    for (genvar k = 0; k < SQ_N; k++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                sq_v[k+1] <= 1'b0;
            end else if (en) begin
                sq_v[k+1] <= sq_v[k];
            end
            if (en) begin
                sq_job[k+1] <= sq_job[k];
                sq_st[k+1]  <= sq_step(sq_st[k]);
            end
        end
    end

    // round the root, form both numerators and their magnitudes
    always_comb begin
        n_s = sq_st[SQ_N].root;
        if (ROOT_W'(sq_st[SQ_N].rem) > sq_st[SQ_N].root) n_s = n_s + 1'b1;
        if (sq_job[SQ_N].kind == KIND_TWO) begin
            n_nump = NUM_W'(sq_job[SQ_N].nb) + $signed({1'b0, n_s});
            n_numm = NUM_W'(sq_job[SQ_N].nb) - $signed({1'b0, n_s});
        end else begin
            n_nump = NUM_W'(sq_job[SQ_N].nb);
            n_numm = NUM_W'(sq_job[SQ_N].nb);
        end
        n_magp = n_nump[NUM_W-1] ? ROOT_W'(-n_nump) : ROOT_W'(n_nump);
        n_magm = n_numm[NUM_W-1] ? ROOT_W'(-n_numm) : ROOT_W'(n_numm);
        n_am   = sq_job[SQ_N].a[COEF_W-1] ? COEF_W'(-sq_job[SQ_N].a)
                                          : COEF_W'(sq_job[SQ_N].a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            dv_v[0] <= 1'b0;
        end else if (en) begin
            dv_v[0] <= sq_v[SQ_N];
        end
        if (en) begin
            dv_kind[0]  <= sq_job[SQ_N].kind;
            dv_np[0]    <= n_nump[NUM_W-1] != sq_job[SQ_N].a[COEF_W-1];
            dv_nm[0]    <= n_numm[NUM_W-1] != sq_job[SQ_N].a[COEF_W-1];
            dv_md[0]    <= {n_am, 1'b0};
            dv_p[0].rem <= '0;
            dv_p[0].quo <= '0;
            dv_p[0].dvd <= MN_W'({n_magp, {FRAC_BITS{1'b0}}}) + MN_W'(n_am);
            dv_m[0].rem <= '0;
            dv_m[0].quo <= '0;
            dv_m[0].dvd <= MN_W'({n_magm, {FRAC_BITS{1'b0}}}) + MN_W'(n_am);
        end
    end

    for (genvar j = 0; j < MN_W; j++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                dv_v[j+1] <= 1'b0;
            end else if (en) begin
                dv_v[j+1] <= dv_v[j];
            end
            if (en) begin
                dv_kind[j+1] <= dv_kind[j];
                dv_np[j+1]   <= dv_np[j];
                dv_nm[j+1]   <= dv_nm[j];
                dv_md[j+1]   <= dv_md[j];
                dv_p[j+1]    <= div_step(dv_p[j], dv_md[j]);
                dv_m[j+1]    <= div_step(dv_m[j], dv_md[j]);
            end
        end
    end

    // saturate to the coefficient range
    function automatic logic [COEF_W:0] sat(input logic [MN_W-1:0] q, input logic neg);
        logic [COEF_W-1:0] v;
        logic              c;
        c = 1'b0;
        if (q == '0) begin
            v = '0;
        end else if (neg) begin
            if (q > MN_W'({1'b1, {(COEF_W-1){1'b0}}})) begin
                v = {1'b1, {(COEF_W-1){1'b0}}};
                c = 1'b1;
            end else begin
                v = COEF_W'(-q);
            end
        end else begin
            if (q > MN_W'({1'b0, {(COEF_W-1){1'b1}}})) begin
                v = {1'b0, {(COEF_W-1){1'b1}}};
                c = 1'b1;
            end else begin
                v = q[COEF_W-1:0];
            end
        end
        return {c, v};
    endfunction

    always_comb begin
        {n_cp, n_rp} = sat(dv_p[MN_W].quo, dv_np[MN_W]);
        {n_cm, n_rm} = sat(dv_m[MN_W].quo, dv_nm[MN_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= dv_v[MN_W];
        end
        if (en) begin
            r_kind <= dv_kind[MN_W];
            if (dv_kind[MN_W] == KIND_DOUBLE || dv_kind[MN_W] == KIND_TWO) begin
                r_plus  <= n_rp;
                r_minus <= n_rm;
                r_clip  <= n_cp || n_cm;
            end else begin
                r_plus  <= '0;
                r_minus <= '0;
                r_clip  <= 1'b0;
            end
        end
    end

    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && (r_kind == KIND_NOT_QUAD || r_kind == KIND_NO_REAL)
        |-> r_plus == '0 && r_minus == '0 && !r_clip)
        else $error("absent roots not zero");
    a_double_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_kind == KIND_DOUBLE |-> r_plus == r_minus)
        else $error("double root mismatch");

endmodule

[hdl/quadratic_root_solver.sv]
// Top level of the quadratic root solver: streaming ports and tolerance register.
// Depends on qrs_pkg, qrs_front, qrs_queue and qrs_back.
//
// Usage:
//   Slave stream carries one request per beat: coefficients a, b, c in
//   signed Q16.16. Master stream returns one result per request, in order:
//   tuser holds the root kind (0 not quadratic, 1 no real roots, 2 double
//   root, 3 two roots), tdata holds both roots and the saturation flag.
//   The cfg channel writes the tolerance (Q16.16, 31 bits); it is always
//   ready. The user must write it only while no request is in flight; the
//   block does not enforce it. Reset sets tolerance 2^-16, clears all stages.
// Timing:
//   One request per cycle sustained while the receiver keeps tready high.
//   90 registers sit in line: 2 front stages (multipliers, discriminant),
//   the queue, 34 square-root stages (two radicand bits each), a rounding
//   stage, 51 divider stages (one quotient bit each) and an output
//   register.
// Stalls:
//   When tready is low with a result pending, the whole back end freezes;
//   the front end keeps filling the 4-entry queue and then drops its tready.
module quadratic_root_solver import qrs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // coef_a, coef_b, coef_c
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // root_plus, root_minus, clipped, zero pad
    output logic [1:0]  m_axis_tuser,   // root_kind
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_data      // tolerance
);

    logic [TOL_W-1:0]  r_tol;
    logic              push, full, pop, q_valid;
    t_job              f_job, q_job;
    logic [COEF_W-1:0] plus, minus;
    logic              clip;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_W'(1);
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    qrs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_a     (s_axis_tdata[31:0]),
        .i_b     (s_axis_tdata[63:32]),
        .i_c     (s_axis_tdata[95:64]),
        .i_tol   (r_tol),
        .o_push  (push),
        .i_full  (full),
        .o_job   (f_job)
    );

    qrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    qrs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (m_axis_tuser),
        .o_plus  (plus),
        .o_minus (minus),
        .o_clip  (clip)
    );

    assign m_axis_tdata = {7'd0, clip, minus, plus};

endmodule
